[design/lmm_pkg.sv]
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared types and constants of the four-neighbor local minimum marker.
// ----------------------------------------------------------------------------
package lmm_pkg;

    localparam int IDX_W      = 6;
    localparam int CFG_W      = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic REG_FRAME_HEIGHT = 1'b0;
    localparam logic REG_FRAME_WIDTH  = 1'b1;

    typedef struct packed {
        logic             is_minimum;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             size_error;
        logic             frame_last;
    } result_t;

endpackage

[design/lmm_cell.sv]
// ----------------------------------------------------------------------------
// lmm_cell
// One cell of the two line delays: shifts from its neighbor or loads at the
// entry point set by the frame width.
// ----------------------------------------------------------------------------
module lmm_cell #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         shift_en,
    input  logic         load,
    input  logic [W-1:0] new_a,
    input  logic [W-1:0] new_b,
    input  logic [W-1:0] nbr_a,
    input  logic [W-1:0] nbr_b,
    output logic [W-1:0] a_q,
    output logic [W-1:0] b_q
);

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;

    always_comb begin
        a_next = load ? new_a : nbr_a;
        b_next = load ? new_b : nbr_b;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign a_q = a_reg;
    assign b_q = b_reg;

endmodule

[design/lmm_out_fifo.sv]
// ----------------------------------------------------------------------------
// lmm_out_fifo
// Result queue; takes up to two results per cycle, delivers one per beat.
// ----------------------------------------------------------------------------
module lmm_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_cnt,
    input  lmm_pkg::result_t push_first,
    input  lmm_pkg::result_t push_second,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output lmm_pkg::result_t head
);
    import lmm_pkg::*;

    result_t                mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [FIFO_PTR_W-1:0]  wr_ptr_plus1;
    logic                   pop;

    assign m_valid      = (count_reg != '0);
    assign pop          = m_valid && m_ready;
    assign room         = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head         = mem[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/local_minimum_marker_4_neighbour.sv]
// Results are queued on their sample's beat and offered on m_* in order.
// Throughput: one sample per cycle while the result queue has room; on the last
// row each sample yields two results, so the 4-entry result queue holds input back.
// Reset (aresetn low, synchronous): row/column counters and result queue
// cleared, frame_height and frame_width back to 64. Line cells are not reset.
// ----------------------------------------------------------------------------
// local_minimum_marker_4_neighbour
// Marks interior points of a raster height map whose four neighbors are not
// smaller; two width-programmable line delays built from a chain of cells.
// ----------------------------------------------------------------------------
module local_minimum_marker_4_neighbour #(
    parameter int MAX_DIM     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // samples in; tdata: sample
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // marks out; tdata: is_minimum, row_index, col_index (zero padded)
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,
    // tuser: size_error
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast
);
    import lmm_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);

    function automatic logic [DW-1:0] eff_size(input logic [CFG_W-1:0] raw);
        int v;
        v = int'(raw);
        if (v == 0) v = 1;
        if (v > MAX_DIM) v = MAX_DIM;
        return DW'(v);
    endfunction

    // configuration
    logic [CFG_W-1:0] height_reg, width_reg;
    logic             cfg_wr;
    logic [DW-1:0]    h_eff, w_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] == REG_FRAME_WIDTH) ? width_reg : height_reg};
    assign h_eff  = eff_size(height_reg);
    assign w_eff  = eff_size(width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= CFG_RESET;
            width_reg  <= CFG_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                default:          height_reg <= height_reg;
            endcase
        end
    end

    // counters
    logic [CW-1:0] row_reg, row_next, col_reg, col_next;
    logic          accept;
    logic          col_wrap, row_wrap;

    assign accept   = s_tvalid && s_tready;
    assign col_wrap = (int'(col_reg) + 1 >= int'(w_eff));
    assign row_wrap = (int'(row_reg) + 1 >= int'(h_eff));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : CW'(int'(row_reg) + 1);
            end else begin
                col_next = CW'(int'(col_reg) + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line delays: cell 0 of line a is one row back, of line b two rows back
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] a_chain [0:MAX_DIM];
    logic [SAMPLE_BITS-1:0] b_chain [0:MAX_DIM];
    logic [SAMPLE_BITS-1:0] left_reg;

    assign x                = s_tdata[SAMPLE_BITS-1:0];
    assign a_chain[MAX_DIM] = '0;
    assign b_chain[MAX_DIM] = '0;

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        lmm_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .load     (w_eff == DW'(k + 1)),
            .new_a    (x),
            .new_b    (a_chain[0]),
            .nbr_a    (a_chain[k+1]),
            .nbr_b    (b_chain[k+1]),
            .a_q      (a_chain[k]),
            .b_q      (b_chain[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg <= a_chain[0];
        end
    end

    // marks
    logic        size_err, interior, lower_nbr, has_above, has_own;
    logic [CW+IDX_W-1:0] row_above_x, row_own_x, col_x;
    result_t     above_res, own_res, first_res;
    logic [1:0]  push_cnt;
    result_t     head;

    assign size_err  = (int'(w_eff) < 3) && (int'(h_eff) < 3);
    assign interior  = (int'(row_reg) >= 2) && (col_reg != '0) && !col_wrap;
    assign lower_nbr = ($signed(b_chain[0]) < $signed(a_chain[0]))
                    || ($signed(x)          < $signed(a_chain[0]))
                    || ($signed(left_reg)   < $signed(a_chain[0]))
                    || ($signed(a_chain[1]) < $signed(a_chain[0]));
    assign has_above = (row_reg != '0);
    assign has_own   = row_wrap;

    assign row_above_x = {{IDX_W{1'b0}}, CW'(int'(row_reg) - 1)};
    assign row_own_x   = {{IDX_W{1'b0}}, row_reg};
    assign col_x       = {{IDX_W{1'b0}}, col_reg};

    always_comb begin
        above_res.is_minimum = interior && !size_err && !lower_nbr;
        above_res.row_index  = row_above_x[IDX_W-1:0];
        above_res.col_index  = col_x[IDX_W-1:0];
        above_res.size_error = size_err;
        above_res.frame_last = 1'b0;
        own_res.is_minimum   = 1'b0;
        own_res.row_index    = row_own_x[IDX_W-1:0];
        own_res.col_index    = col_x[IDX_W-1:0];
        own_res.size_error   = size_err;
        own_res.frame_last   = col_wrap;
        first_res            = has_above ? above_res : own_res;
        push_cnt             = accept ? (2'(has_above) + 2'(has_own)) : 2'd0;
    end

    lmm_out_fifo u_out_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_cnt    (push_cnt),
        .push_first  (first_res),
        .push_second (own_res),
        .room        (s_tready),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .head        (head)
    );

    assign m_tdata = {3'b000, head.col_index, head.row_index, head.is_minimum};
    assign m_tuser = head.size_error;
    assign m_tlast = head.frame_last;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (has_above || has_own) |=> m_tvalid)
        else $error("accepted sample produced no result");

    a_err_no_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[0])
        else $error("mark set under size error");

    a_last_no_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[0])
        else $error("border point marked on frame end");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (row_reg == '0) && (col_reg == '0))
        else $error("frame not restarted on register write");
`endif

endmodule

[tb/sv/local_minimum_marker_4_neighbour_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_minimum_marker_4_neighbour_test
// Streams height maps through the marker and checks every mark against an
// in-bench predictor. Covers several frame sizes set over APB (zero and
// oversize values included), size errors, single rows, and frames cut short
// by a register write. Idle bursts fall on both stream sides, and one long
// receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module local_minimum_marker_4_neighbour_test;
    import lmm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int DIM_MAX        = 64;
    localparam int TOTAL_SAMPLES  = 550;
    localparam int CALM_AFTER     = 470;
    localparam int STALL_AFTER    = 150;
    localparam int STALL_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PRINT_LIMIT    = 100;

    localparam logic signed [15:0] PLATEAU_MAP [9] = '{
        16'sh7fff, 16'sh0000, 16'sh7fff,
        -16'sd5,   -16'sd5,   -16'sd5,
        16'sh8000, -16'sd5,   16'sh7fff
    };
    localparam logic signed [15:0] TINY_MAP [4]   = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff};
    localparam logic signed [15:0] SINGLE_ROW [5] = '{16'sh0000, 16'shffff, 16'sh7fff,
                                                      16'sh8000, 16'sh0007};

    class minimum_scoreboard;
        logic [CFG_W-1:0]   height_reg;
        logic [CFG_W-1:0]   width_reg;
        logic signed [15:0] row_above [DIM_MAX];
        logic signed [15:0] row_above2 [DIM_MAX];
        int unsigned        row_pos;
        int unsigned        col_pos;
        result_t            marks_due [$];
        int                 mismatches;
        int                 marks_seen;
        int                 minima_seen;

        function new();
            height_reg = CFG_RESET;
            width_reg  = CFG_RESET;
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            row_pos     = 0;
            col_pos     = 0;
            mismatches  = 0;
            marks_seen  = 0;
            minima_seen = 0;
        endfunction

        function int unsigned eff_size(logic [CFG_W-1:0] raw);
            int unsigned v;
            v = 32'(raw);
            if (v == 0) v = 1;
            if (v > DIM_MAX) v = DIM_MAX;
            return v;
        endfunction

        function void set_size(logic reg_sel, logic [31:0] value);
            if (reg_sel == REG_FRAME_HEIGHT) begin
                height_reg = value[CFG_W-1:0];
            end else begin
                width_reg = value[CFG_W-1:0];
            end
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void note_sample(logic signed [15:0] x);
            int unsigned        h, w, r, c;
            logic               err;
            logic signed [15:0] mid;
            result_t            m;
            h   = eff_size(height_reg);
            w   = eff_size(width_reg);
            r   = row_pos;
            c   = col_pos;
            err = (w < 3) && (h < 3);
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            // mark for the point one row up
            if (r >= 1) begin
                m            = '0;
                m.row_index  = IDX_W'(r - 1);
                m.col_index  = IDX_W'(c);
                m.size_error = err;
                if (r >= 2 && c >= 1 && c + 1 < w && !err) begin
                    mid = row_above[c];
                    m.is_minimum = !(row_above2[c] < mid || x < mid ||
                                     row_above2[c-1] < mid || row_above[c+1] < mid);
                end
                marks_due.push_back(m);
            end
            row_above2[c] = row_above[c];
            row_above[c]  = x;
            // last row marks itself, always zero
            if (r + 1 >= h) begin
                m            = '0;
                m.row_index  = IDX_W'(r);
                m.col_index  = IDX_W'(c);
                m.size_error = err;
                m.frame_last = (c + 1 >= w);
                marks_due.push_back(m);
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            // beyond the limit, mismatches are only counted
            if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_mark(result_t got);
            result_t want;
            if (marks_due.size() == 0) begin
                report_mismatch($sformatf("unexpected mark row %0d col %0d",
                                          got.row_index, got.col_index));
                return;
            end
            want = marks_due.pop_front();
            marks_seen++;
            if (got.is_minimum) minima_seen++;
            if (got.is_minimum !== want.is_minimum)
                report_mismatch($sformatf("is_minimum at (%0d,%0d): got %b want %b",
                    want.row_index, want.col_index, got.is_minimum, want.is_minimum));
            if (got.row_index !== want.row_index)
                report_mismatch($sformatf("row_index: got %0d want %0d",
                    got.row_index, want.row_index));
            if (got.col_index !== want.col_index)
                report_mismatch($sformatf("col_index: got %0d want %0d",
                    got.col_index, want.col_index));
            if (got.size_error !== want.size_error)
                report_mismatch($sformatf("size_error at (%0d,%0d): got %b want %b",
                    want.row_index, want.col_index, got.size_error, want.size_error));
            if (got.frame_last !== want.frame_last)
                report_mismatch($sformatf("frame_last at (%0d,%0d): got %b want %b",
                    want.row_index, want.col_index, got.frame_last, want.frame_last));
        endtask

        task report_leftover();
            while (marks_due.size() != 0) begin
                report_mismatch($sformatf("mark row %0d col %0d never arrived",
                    marks_due[0].row_index, marks_due[0].col_index));
                void'(marks_due.pop_front());
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // is_minimum, row_index, col_index
    logic [0:0]  m_tuser;          // size_error
    logic        m_tlast;

    minimum_scoreboard sb = new();
    int samples_in   = 0;
    int quiet_cycles = 0;
    int writes_done  = 0;
    int idle_pct     = 20;

    local_minimum_marker_4_neighbour i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin : monitor
        result_t got;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) sb.set_size(paddr[2], pwdata);
            if (s_tvalid && s_tready) begin
                sb.note_sample(s_tdata);
                samples_in++;
            end
            if (m_tvalid && m_tready) begin
                got.is_minimum = m_tdata[0];
                got.row_index  = m_tdata[6:1];
                got.col_index  = m_tdata[12:7];
                got.size_error = m_tuser[0];
                got.frame_last = m_tlast;
                sb.check_mark(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic bit take_break();
        return samples_in < CALM_AFTER && idle_pct != 0 && $urandom_range(0, 99) < idle_pct;
    endfunction

    initial begin : mark_sink
        bit stalled_once;
        stalled_once = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!stalled_once && samples_in >= STALL_AFTER) begin
                stalled_once = 1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (take_break()) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(logic signed [15:0] x);
        @(negedge aclk);
        if (take_break()) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // block must be idle before any register write
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.marks_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_sel, logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {25'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        writes_done++;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] height, logic [CFG_W-1:0] width);
        if ($urandom_range(0, 1)) begin
            apb_write(REG_FRAME_HEIGHT, height);
            apb_write(REG_FRAME_WIDTH, width);
        end else begin
            apb_write(REG_FRAME_WIDTH, width);
            apb_write(REG_FRAME_HEIGHT, height);
        end
    endtask

    // 0: narrow range, many ties; 1: full range; 2: extremes
    function automatic logic signed [15:0] pick_sample(int unsigned style);
        int v;
        case (style)
            0: begin
                v = int'($urandom_range(0, 6)) - 3;
                return 16'(v);
            end
            1: return 16'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'shffff;
                    default: return 16'($urandom_range(0, 3));
                endcase
            end
        endcase
    endfunction

    task automatic run_random_phase();
        logic [CFG_W-1:0] hv, wv;
        int unsigned      hs, ws, count, style;
        case ($urandom_range(0, 9))
            0: wv = '0;
            1: wv = CFG_W'($urandom_range(65, 127));
            2: wv = CFG_W'(DIM_MAX);
            3: wv = CFG_W'($urandom_range(1, 2));
            default: wv = CFG_W'($urandom_range(3, 8));
        endcase
        ws = sb.eff_size(wv);
        if (ws > 8) begin
            hv = CFG_W'($urandom_range(0, 4));
        end else if (ws <= 3 && $urandom_range(0, 3) == 0) begin
            hv = $urandom_range(0, 1) ? CFG_W'(DIM_MAX) : CFG_W'($urandom_range(65, 127));
        end else begin
            case ($urandom_range(0, 5))
                0: hv = '0;
                1: hv = CFG_W'($urandom_range(1, 2));
                default: hv = CFG_W'($urandom_range(3, 8));
            endcase
        end
        hs    = sb.eff_size(hv);
        count = hs * ws;
        if (count <= 100 && $urandom_range(0, 1)) count = count * 2;
        // cut short: the next write restarts mid-frame
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        if (count > 32'(TOTAL_SAMPLES - samples_in)) count = 32'(TOTAL_SAMPLES - samples_in);
        style = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 40;
        endcase
        settle();
        set_frame(hv, wv);
        repeat (count) send_sample($urandom_range(0, 9) == 0 ? pick_sample(1) : pick_sample(style));
    endtask

    initial begin : stimulus
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        set_frame(7'd3, 7'd3);
        foreach (PLATEAU_MAP[i]) send_sample(PLATEAU_MAP[i]);
        settle();
        set_frame(7'd2, 7'd2);
        foreach (TINY_MAP[i]) send_sample(TINY_MAP[i]);
        settle();
        set_frame(7'd0, 7'd5);
        foreach (SINGLE_ROW[i]) send_sample(SINGLE_ROW[i]);

        while (samples_in < TOTAL_SAMPLES) run_random_phase();

        settle();
        sb.report_leftover();
        $display("Covered %0d samples and %0d marks (%0d minima) over %0d register writes,",
                 samples_in, sb.marks_seen, sb.minima_seen, writes_done);
        $display("with frame sizes from 1 to 64 per side, size errors and cut-short frames.");
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
